// ===== hdl/swqt_pkg.sv =====
package swqt_pkg;

	localparam int MaxProcsDef = 32;
	localparam int KeyWidthDef = 32;

	localparam logic [1:0] KIND_BLOCK   = 2'd0;
	localparam logic [1:0] KIND_RELEASE = 2'd1;
	localparam logic [1:0] KIND_REMOVE  = 2'd2;
	localparam logic [1:0] KIND_PEEK    = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_FREE = 2'd1;
	localparam logic [1:0] ST_MISSING = 2'd2;
	localparam logic [1:0] ST_BLOCKED = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] sem_key;
		logic [4:0]  proc_id;
	} in_word_t;

	typedef struct packed {
		logic [1:0] status;
		logic [4:0] result_proc;
		logic       proc_valid;
	} out_word_t;

endpackage

// ===== hdl/swqt_search.sv =====
module swqt_search import swqt_pkg::*; #(
	parameter int MAX_PROCS = MaxProcsDef,
	parameter int KEY_WIDTH = KeyWidthDef,
	localparam int DW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [KEY_WIDTH-1:0] key,
	input  logic                 key_wr,
	input  logic [DW-1:0]        key_wr_addr,
	input  logic [KEY_WIDTH-1:0] key_wr_data,
	input  logic [MAX_PROCS-1:0] in_use,
	output logic                 done,
	output logic                 found,
	output logic [DW-1:0]        found_idx
);

	// Key store: one write port, one registered read port, walked one entry a cycle.
	logic [KEY_WIDTH-1:0] key_mem [MAX_PROCS];
	logic [KEY_WIDTH-1:0] rd_key_q;
	logic [DW:0]          rd_cnt_q;
	logic [DW-1:0]        cmp_idx_q;
	logic                 cmp_vld_q;
	logic                 busy_q;

	always_ff @(posedge clk) begin
		if (key_wr) begin
			key_mem[key_wr_addr] <= key_wr_data;
		end
		rd_key_q <= key_mem[rd_cnt_q[DW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			rd_cnt_q  <= '0;
			cmp_idx_q <= '0;
			cmp_vld_q <= 1'b0;
			done      <= 1'b0;
			found     <= 1'b0;
			found_idx <= '0;
		end else begin
			done      <= 1'b0;
			cmp_vld_q <= 1'b0;
			if (start) begin
				busy_q   <= 1'b1;
				rd_cnt_q <= '0;
				found    <= 1'b0;
			end else if (busy_q) begin
				if (rd_cnt_q < (DW+1)'(MAX_PROCS)) begin
					cmp_vld_q <= 1'b1;
					cmp_idx_q <= rd_cnt_q[DW-1:0];
					rd_cnt_q  <= rd_cnt_q + 1'b1;
				end
				if (cmp_vld_q && !found && in_use[cmp_idx_q] && rd_key_q == key) begin
					found     <= 1'b1;
					found_idx <= cmp_idx_q;
				end
				if (cmp_vld_q && cmp_idx_q == DW'(MAX_PROCS - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== hdl/swqt_lists.sv =====
module swqt_lists import swqt_pkg::*; #(
	parameter int MAX_PROCS = MaxProcsDef,
	localparam int DW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [DW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic [DW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	// One link array (next, prev, head, tail or owner), registered read.
	logic [DW-1:0] mem [MAX_PROCS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== hdl/semaphore_wait_queue_table.sv =====
// Channel | Dir | Handshake     | Word
// in      | in  | in_valid/stall | in_word_t  (kind, sem_key, proc_id)
// out     | out | out_valid/stall| out_word_t (status, result_proc, proc_valid)
//
// One word is worked at a time. Block, release and peek walk the key memory one
// entry per cycle. A remove-named, a word rejected on its key and a double block
// skip the walk. in_stall falls in the same cycle that out_valid rises.
// Reset clears the used and blocked marks (flip-flops); the link memories
// need no clearing. The result register frees the sequencer: a new word is
// taken while an earlier result still waits under out stall.
module semaphore_wait_queue_table import swqt_pkg::*; #(
	parameter int MAX_PROCS = MaxProcsDef,
	parameter int KEY_WIDTH = KeyWidthDef,
	localparam int DW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_word_t  in_word,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_word
);

	typedef enum logic [3:0] {
		S_IDLE, S_SEARCH, S_DISPATCH, S_RD1, S_RD1W, S_RD2, S_RD2W, S_UPD, S_RESULT
	} state_t;

	state_t               state_q;
	logic [1:0]           kind_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [MAX_PROCS-1:0] in_use_q;
	logic [MAX_PROCS-1:0] blocked_q;
	logic [DW-1:0]        d_q;
	logic [DW-1:0]        p_q;
	logic [DW-1:0]        h_q;
	logic [DW-1:0]        t_q;
	logic [DW-1:0]        nx_q;
	logic [DW-1:0]        pv_q;
	logic [1:0]           status_q;
	logic [4:0]           rproc_q;
	logic                 pvalid_q;
	logic                 res_pend_q;

	// Key checks on the incoming word.
	logic [KEY_WIDTH-1:0] in_key;
	logic                 key_ok;
	logic                 pid_ok;
	assign in_key = KEY_WIDTH'(in_word.sem_key);
	assign key_ok = (in_key != '0) && (in_key != '1);
	assign pid_ok = 32'(in_word.proc_id) < MAX_PROCS;

	// Lowest free descriptor.
	logic          free_any;
	logic [DW-1:0] free_idx;
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = MAX_PROCS - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				free_any = 1'b1;
				free_idx = DW'(i);
			end
		end
	end

	logic          srch_start;
	logic          srch_done;
	logic          srch_found;
	logic [DW-1:0] srch_idx;
	logic          key_wr;

	swqt_search #(.MAX_PROCS(MAX_PROCS), .KEY_WIDTH(KEY_WIDTH)) u_search (
		.clk, .arst_n,
		.start(srch_start), .key(key_q),
		.key_wr, .key_wr_addr(free_idx), .key_wr_data(key_q),
		.in_use(in_use_q),
		.done(srch_done), .found(srch_found), .found_idx(srch_idx)
	);

	// Five link memories: head, tail per descriptor; next, prev, owner per process.
	logic          hd_we, tl_we, nx_we, pv_we, ow_we;
	logic [DW-1:0] hd_wa, tl_wa, nx_wa, pv_wa, ow_wa;
	logic [DW-1:0] hd_wd, tl_wd, nx_wd, pv_wd, ow_wd;
	logic [DW-1:0] hd_ra, nx_ra, ow_ra;
	logic [DW-1:0] hd_rd, tl_rd, nx_rd, pv_rd, ow_rd;

	swqt_lists #(.MAX_PROCS(MAX_PROCS)) u_head (.clk, .wr_en(hd_we), .wr_addr(hd_wa),
		.wr_data(hd_wd), .rd_addr(hd_ra), .rd_data(hd_rd));
	swqt_lists #(.MAX_PROCS(MAX_PROCS)) u_tail (.clk, .wr_en(tl_we), .wr_addr(tl_wa),
		.wr_data(tl_wd), .rd_addr(hd_ra), .rd_data(tl_rd));
	swqt_lists #(.MAX_PROCS(MAX_PROCS)) u_next (.clk, .wr_en(nx_we), .wr_addr(nx_wa),
		.wr_data(nx_wd), .rd_addr(nx_ra), .rd_data(nx_rd));
	swqt_lists #(.MAX_PROCS(MAX_PROCS)) u_prev (.clk, .wr_en(pv_we), .wr_addr(pv_wa),
		.wr_data(pv_wd), .rd_addr(nx_ra), .rd_data(pv_rd));
	swqt_lists #(.MAX_PROCS(MAX_PROCS)) u_own (.clk, .wr_en(ow_we), .wr_addr(ow_wa),
		.wr_data(ow_wd), .rd_addr(ow_ra), .rd_data(ow_rd));

	// Read addresses follow the step: head/tail by descriptor, links by process.
	assign hd_ra = d_q;
	assign nx_ra = p_q;
	assign ow_ra = p_q;

	assign in_stall = (state_q != S_IDLE) || res_pend_q;
	assign srch_start = (state_q == S_IDLE) && in_valid && !in_stall && key_ok
		&& in_word.kind != KIND_REMOVE
		&& !(in_word.kind == KIND_BLOCK && (!pid_ok || blocked_q[in_word.proc_id[DW-1:0]]));

	// Unlink decisions, used in S_UPD (h_q/t_q/nx_q/pv_q valid).
	logic is_head, is_tail;
	assign is_head = (h_q == p_q);
	assign is_tail = (t_q == p_q);
	logic new_desc;
	assign new_desc = (kind_q == KIND_BLOCK) && !srch_found;
	assign key_wr = (state_q == S_DISPATCH) && new_desc && free_any;

	always_comb begin
		hd_we = 1'b0; tl_we = 1'b0; nx_we = 1'b0; pv_we = 1'b0; ow_we = 1'b0;
		hd_wa = d_q;  tl_wa = d_q;  nx_wa = p_q;  pv_wa = p_q;  ow_wa = p_q;
		hd_wd = p_q;  tl_wd = p_q;  nx_wd = p_q;  pv_wd = t_q;  ow_wd = d_q;
		if (state_q == S_DISPATCH && key_wr) begin
			hd_we = 1'b1; tl_we = 1'b1; ow_we = 1'b1;
			hd_wa = free_idx; tl_wa = free_idx; ow_wd = free_idx;
		end
		if (state_q == S_UPD) begin
			if (kind_q == KIND_BLOCK) begin
				// Append p after tail t.
				nx_we = 1'b1; nx_wa = t_q; nx_wd = p_q;
				pv_we = 1'b1; pv_wa = p_q; pv_wd = t_q;
				tl_we = 1'b1;
				ow_we = 1'b1;
			end else if (!(is_head && is_tail)) begin
				if (is_head) begin
					hd_we = 1'b1; hd_wd = nx_q;
				end else if (is_tail) begin
					tl_we = 1'b1; tl_wd = pv_q;
				end else begin
					nx_we = 1'b1; nx_wa = pv_q; nx_wd = nx_q;
					pv_we = 1'b1; pv_wa = nx_q; pv_wd = pv_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			kind_q     <= KIND_BLOCK;
			key_q      <= '0;
			in_use_q   <= '0;
			blocked_q  <= '0;
			d_q        <= '0;
			p_q        <= '0;
			h_q        <= '0;
			t_q        <= '0;
			nx_q       <= '0;
			pv_q       <= '0;
			res_pend_q <= 1'b0;
			out_valid  <= 1'b0;
			out_word   <= '0;
			status_q   <= ST_MISSING;
			rproc_q    <= '0;
			pvalid_q   <= 1'b0;
		end else begin
			if (res_pend_q && (!out_valid || !out_stall)) begin
				out_valid  <= 1'b1;
				res_pend_q <= 1'b0;
				out_word   <= '{status: status_q, result_proc: rproc_q, proc_valid: pvalid_q};
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && !in_stall) begin
						kind_q   <= in_word.kind;
						key_q    <= in_key;
						p_q      <= in_word.proc_id[DW-1:0];
						rproc_q  <= '0;
						pvalid_q <= 1'b0;
						if (srch_start) begin
							status_q <= ST_MISSING;
							state_q  <= S_SEARCH;
						end else if (in_word.kind == KIND_BLOCK && pid_ok && key_ok) begin
							status_q <= ST_BLOCKED;
							state_q  <= S_RESULT;
						end else if (in_word.kind == KIND_REMOVE && pid_ok
								&& blocked_q[in_word.proc_id[DW-1:0]]) begin
							status_q <= ST_MISSING;
							state_q  <= S_RD1;
						end else begin
							status_q <= ST_MISSING;
							state_q  <= S_RESULT;
						end
					end
				end
				S_SEARCH: begin
					if (srch_done) begin
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					d_q <= srch_idx;
					if (new_desc) begin
						if (free_any) begin
							in_use_q[free_idx] <= 1'b1;
							blocked_q[p_q]     <= 1'b1;
							status_q           <= ST_OK;
						end else begin
							status_q <= ST_NO_FREE;
						end
						state_q <= S_RESULT;
					end else if (!srch_found) begin
						state_q <= S_RESULT;
					end else begin
						state_q <= S_RD2;
					end
				end
				S_RD1: begin
					// Remove named: read owner of p.
					state_q <= S_RD1W;
				end
				S_RD1W: begin
					d_q     <= ow_rd;
					state_q <= S_RD2;
				end
				S_RD2: begin
					state_q <= S_RD2W;
				end
				S_RD2W: begin
					h_q <= hd_rd;
					t_q <= tl_rd;
					if (kind_q == KIND_RELEASE || kind_q == KIND_PEEK) begin
						p_q      <= hd_rd;
						status_q <= ST_OK;
						rproc_q  <= 5'(hd_rd);
						pvalid_q <= 1'b1;
						state_q  <= (kind_q == KIND_PEEK) ? S_RESULT : S_RD1;
						kind_q   <= (kind_q == KIND_PEEK) ? KIND_PEEK : KIND_REMOVE;
					end else begin
						if (kind_q == KIND_REMOVE) begin
							// The process being unlinked is the one returned.
							status_q <= ST_OK;
							rproc_q  <= 5'(p_q);
							pvalid_q <= 1'b1;
						end
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (kind_q == KIND_BLOCK) begin
						blocked_q[p_q] <= 1'b1;
						status_q       <= ST_OK;
					end else begin
						blocked_q[p_q] <= 1'b0;
						if (is_head && is_tail) begin
							in_use_q[d_q] <= 1'b0;
						end
					end
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					res_pend_q <= 1'b1;
					state_q    <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			// Link reads for the unlink step are registered and captured in S_RD2W.
			if (state_q == S_RD2W) begin
				nx_q <= nx_rd;
				pv_q <= pv_rd;
			end
		end
	end

	// A release re-enters S_RD1 with p set to the head; the owner is re-read and
	// equals d, and the links of p are captured again in S_RD2W.

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> state_q == S_IDLE)
		else $error("accepting while busy");
	a_res_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RESULT |=> res_pend_q)
		else $error("result lost");
	a_pvalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_word.proc_valid |-> out_word.result_proc == '0)
		else $error("stray process id");

endmodule
